// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the vertex transform block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define VTP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vertex transform assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define VTP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vertex transform assertion failed");

`endif

// ----- sv/vtp_pkg.sv -----
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared widths, configuration and sideband types of the vertex transform.
// ----------------------------------------------------------------------------
package vtp_pkg;

  localparam int PT_W   = 16;
  localparam int TX_W   = 17;
  localparam int PROD_W = 33;
  localparam int DOT_W  = 35;
  localparam int D_W    = 36;
  localparam int DEN_W  = 37;
  localparam int MAG_W  = 34;
  localparam int MT_W   = 24;
  localparam int NUM_W  = 58;
  localparam int MD_W   = 36;
  localparam int Q_W    = 60;
  localparam int CL_W   = 38;
  localparam int ZM_W   = 47;
  localparam int OUT_W  = 32;
  localparam int DIV_N  = NUM_W;

  localparam logic [2:0] REG_ROW_X     = 3'd0;
  localparam logic [2:0] REG_ROW_Y     = 3'd1;
  localparam logic [2:0] REG_ROW_DEPTH = 3'd2;
  localparam logic [2:0] REG_CENTER_X  = 3'd3;
  localparam logic [2:0] REG_CENTER_Y  = 3'd4;
  localparam logic [2:0] REG_CENTER_Z  = 3'd5;
  localparam logic [2:0] REG_ZOOM      = 3'd6;

  typedef struct packed {
    logic [63:0] row_x;
    logic [63:0] row_y;
    logic [63:0] row_depth;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] center_z;
    logic [7:0]  zoom;
  } cfg_t;

  typedef struct packed {
    logic              err;
    logic              neg_x;
    logic              neg_y;
    logic [OUT_W-1:0]  depth;
  } side_t;

endpackage

// ----- sv/vtp_cfg.sv -----
// ----------------------------------------------------------------------------
// vtp_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module vtp_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output vtp_pkg::cfg_t cfg
);
  import vtp_pkg::*;

  cfg_t        cfg_r;
  logic        wr_en;
  logic [2:0]  idx;

  assign idx   = paddr[5:3];
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{row_x: '0, row_y: '0, row_depth: '0, center_x: '0, center_y: '0,
                 center_z: '0, zoom: 8'd1};
    end else if (wr_en) begin
      case (idx)
        REG_ROW_X:     cfg_r.row_x     <= pwdata;
        REG_ROW_Y:     cfg_r.row_y     <= pwdata;
        REG_ROW_DEPTH: cfg_r.row_depth <= pwdata;
        REG_CENTER_X:  cfg_r.center_x  <= pwdata[15:0];
        REG_CENTER_Y:  cfg_r.center_y  <= pwdata[15:0];
        REG_CENTER_Z:  cfg_r.center_z  <= pwdata[15:0];
        REG_ZOOM:      cfg_r.zoom      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROW_X:     prdata = cfg_r.row_x;
      REG_ROW_Y:     prdata = cfg_r.row_y;
      REG_ROW_DEPTH: prdata = cfg_r.row_depth;
      REG_CENTER_X:  prdata = {48'd0, cfg_r.center_x};
      REG_CENTER_Y:  prdata = {48'd0, cfg_r.center_y};
      REG_CENTER_Z:  prdata = {48'd0, cfg_r.center_z};
      REG_ZOOM:      prdata = {56'd0, cfg_r.zoom};
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- sv/vtp_front.sv -----
// ----------------------------------------------------------------------------
// vtp_front
// Centering, matrix products, dot sums, depth and divider operand stages.
// ----------------------------------------------------------------------------
module vtp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ce,
  input  vtp_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  input  logic [vtp_pkg::PT_W-1:0]    point_x,
  input  logic [vtp_pkg::PT_W-1:0]    point_y,
  input  logic [vtp_pkg::PT_W-1:0]    point_z,
  output logic                        out_valid,
  output vtp_pkg::side_t              out_side,
  output logic [vtp_pkg::NUM_W-1:0]   num_x,
  output logic [vtp_pkg::NUM_W-1:0]   num_y,
  output logic [vtp_pkg::MD_W-1:0]    md
);
  import vtp_pkg::*;

  logic [4:0] v_r;

  logic signed [TX_W-1:0]   t_r [3];
  logic signed [PROD_W-1:0] p_r [9];
  logic signed [DOT_W-1:0]  dx_r, dy_r, dd_r;

  logic signed [DEN_W-1:0]  den_r;
  logic [MAG_W-1:0]         magx_r, magy_r;
  side_t                    side4_r, side5_r;

  logic [NUM_W-1:0]         numx_r, numy_r;
  logic [MD_W-1:0]          md_r;

  logic signed [15:0]       coef [9];
  logic signed [MT_W-1:0]   td;
  logic signed [D_W-1:0]    d_nxt;
  logic signed [DEN_W-1:0]  den_nxt;
  logic [15:0]              td_mag16;
  logic [MT_W-1:0]          mt;
  logic [DEN_W-1:0]         den_abs;

  always_comb begin
    coef[0] = cfg.row_x[15:0];
    coef[1] = cfg.row_x[31:16];
    coef[2] = cfg.row_x[47:32];
    coef[3] = cfg.row_y[15:0];
    coef[4] = cfg.row_y[31:16];
    coef[5] = cfg.row_y[47:32];
    coef[6] = cfg.row_depth[15:0];
    coef[7] = cfg.row_depth[31:16];
    coef[8] = cfg.row_depth[47:32];
    td       = {cfg.row_depth[63:48], 8'd0};
    d_nxt    = D_W'(dd_r) + D_W'(td);
    den_nxt  = DEN_W'(d_nxt) + DEN_W'(td);
    td_mag16 = cfg.row_depth[63] ? (16'd0 - cfg.row_depth[63:48]) : cfg.row_depth[63:48];
    mt       = {td_mag16, 8'd0};
    den_abs  = den_r[DEN_W-1] ? (DEN_W'(0) - den_r) : den_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      t_r[0] <= TX_W'($signed(point_x)) - TX_W'($signed(cfg.center_x));
      t_r[1] <= TX_W'($signed(point_y)) - TX_W'($signed(cfg.center_y));
      t_r[2] <= TX_W'($signed(point_z)) - TX_W'($signed(cfg.center_z));
      for (int i = 0; i < 9; i++) begin
        p_r[i] <= PROD_W'(t_r[i % 3]) * PROD_W'(coef[i]);
      end
      dx_r <= DOT_W'(p_r[0]) + DOT_W'(p_r[1]) + DOT_W'(p_r[2]);
      dy_r <= DOT_W'(p_r[3]) + DOT_W'(p_r[4]) + DOT_W'(p_r[5]);
      dd_r <= DOT_W'(p_r[6]) + DOT_W'(p_r[7]) + DOT_W'(p_r[8]);
      den_r         <= den_nxt;
      side4_r.err   <= (td == '0) || (den_nxt == '0);
      side4_r.neg_x <= dx_r[DOT_W-1];
      side4_r.neg_y <= dy_r[DOT_W-1];
      side4_r.depth <= d_nxt[D_W-1:4];
      magx_r <= dx_r[DOT_W-1] ? MAG_W'(-dx_r) : MAG_W'(dx_r);
      magy_r <= dy_r[DOT_W-1] ? MAG_W'(-dy_r) : MAG_W'(dy_r);
      side5_r <= side4_r;
      numx_r  <= NUM_W'(magx_r) * NUM_W'(mt);
      numy_r  <= NUM_W'(magy_r) * NUM_W'(mt);
      md_r    <= side4_r.err ? MD_W'(1) : den_abs[MD_W-1:0];
    end
  end

  assign out_valid = v_r[4];
  assign out_side  = side5_r;
  assign num_x     = numx_r;
  assign num_y     = numy_r;
  assign md        = md_r;

endmodule

// ----- sv/vtp_div.sv -----
// ----------------------------------------------------------------------------
// vtp_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vtp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ce,
  input  logic                        in_valid,
  input  vtp_pkg::side_t              in_side,
  input  logic [vtp_pkg::NUM_W-1:0]   num_x,
  input  logic [vtp_pkg::NUM_W-1:0]   num_y,
  input  logic [vtp_pkg::MD_W-1:0]    md,
  output logic                        out_valid,
  output vtp_pkg::side_t              out_side,
  output logic [vtp_pkg::NUM_W-1:0]   quo_x,
  output logic [vtp_pkg::NUM_W-1:0]   quo_y
);
  import vtp_pkg::*;

  logic              v_r    [1:DIV_N];
  side_t             side_r [1:DIV_N];
  logic [NUM_W-1:0]  nx_r   [1:DIV_N];
  logic [NUM_W-1:0]  ny_r   [1:DIV_N];
  logic [MD_W-1:0]   rx_r   [1:DIV_N];
  logic [MD_W-1:0]   ry_r   [1:DIV_N];
  logic [MD_W-1:0]   md_r   [1:DIV_N];

  for (genvar k = 0; k < DIV_N; k++) begin : g_stage
    logic              v_i;
    side_t             side_i;
    logic [NUM_W-1:0]  nx_i, ny_i;
    logic [MD_W-1:0]   rx_i, ry_i, md_i;
    logic [MD_W:0]     trial_x, trial_y;
    logic              ge_x, ge_y;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign side_i = in_side;
      assign nx_i   = num_x;
      assign ny_i   = num_y;
      assign rx_i   = '0;
      assign ry_i   = '0;
      assign md_i   = md;
    end else begin : g_next
      assign v_i    = v_r[k];
      assign side_i = side_r[k];
      assign nx_i   = nx_r[k];
      assign ny_i   = ny_r[k];
      assign rx_i   = rx_r[k];
      assign ry_i   = ry_r[k];
      assign md_i   = md_r[k];
    end

    always_comb begin
      trial_x = {rx_i, nx_i[NUM_W-1]};
      trial_y = {ry_i, ny_i[NUM_W-1]};
      ge_x    = trial_x >= {1'b0, md_i};
      ge_y    = trial_y >= {1'b0, md_i};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (ce) begin
        v_r[k+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        side_r[k+1] <= side_i;
        md_r[k+1]   <= md_i;
        rx_r[k+1]   <= ge_x ? MD_W'(trial_x - {1'b0, md_i}) : MD_W'(trial_x);
        ry_r[k+1]   <= ge_y ? MD_W'(trial_y - {1'b0, md_i}) : MD_W'(trial_y);
        nx_r[k+1]   <= {nx_i[NUM_W-2:0], ge_x};
        ny_r[k+1]   <= {ny_i[NUM_W-2:0], ge_y};
      end
    end
  end

  assign out_valid = v_r[DIV_N];
  assign out_side  = side_r[DIV_N];
  assign quo_x     = nx_r[DIV_N];
  assign quo_y     = ny_r[DIV_N];

endmodule

// ----- sv/vtp_back.sv -----
// ----------------------------------------------------------------------------
// vtp_back
// Sign, translation, clamp, zoom, Q28.4 saturation and the output register.
// ----------------------------------------------------------------------------
module vtp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ce,
  input  vtp_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  input  vtp_pkg::side_t              in_side,
  input  logic [vtp_pkg::NUM_W-1:0]   quo_x,
  input  logic [vtp_pkg::NUM_W-1:0]   quo_y,
  output logic                        out_valid,
  output logic [3*vtp_pkg::OUT_W-1:0] out_data,
  output logic                        out_err
);
  import vtp_pkg::*;

  localparam logic signed [Q_W-1:0]   PRE_POS = 60'sd68719476736;
  localparam logic signed [Q_W-1:0]   PRE_NEG = -60'sd68719476736;
  localparam logic signed [OUT_W-1:0] O_MAX   = 32'sh7fffffff;
  localparam logic signed [OUT_W-1:0] O_MIN   = 32'sh80000000;

  function automatic logic signed [CL_W-1:0] clamp_sum(
    input logic [NUM_W-1:0] q, input logic neg, input logic [15:0] tr);
    logic signed [Q_W-1:0] qs, s;
    qs = neg ? -$signed(Q_W'(q)) : $signed(Q_W'(q));
    s  = qs + Q_W'($signed({tr, 8'd0}));
    if (s > PRE_POS) s = PRE_POS;
    if (s < PRE_NEG) s = PRE_NEG;
    return s[CL_W-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_q8(input logic signed [ZM_W-1:0] m);
    logic signed [ZM_W-5:0] sh;
    sh = m[ZM_W-1:4];
    if (sh > (ZM_W-4)'(O_MAX)) return O_MAX;
    if (sh < (ZM_W-4)'(O_MIN)) return O_MIN;
    return sh[OUT_W-1:0];
  endfunction

  logic [2:0]               v_r;
  side_t                    s1_r, s2_r;
  logic signed [CL_W-1:0]   cx_r, cy_r;
  logic signed [ZM_W-1:0]   mx_r, my_r;
  logic [3*OUT_W-1:0]       data_r;
  logic                     err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_r <= in_side;
      cx_r <= clamp_sum(quo_x, in_side.neg_x, cfg.row_x[63:48]);
      cy_r <= clamp_sum(quo_y, in_side.neg_y, cfg.row_y[63:48]);
      s2_r <= s1_r;
      mx_r <= ZM_W'(cx_r) * ZM_W'($signed({1'b0, cfg.zoom}));
      my_r <= ZM_W'(cy_r) * ZM_W'($signed({1'b0, cfg.zoom}));
      err_r <= s2_r.err;
      data_r[OUT_W-1:0]       <= s2_r.err ? (s2_r.neg_x ? O_MIN : O_MAX) : sat_q8(mx_r);
      data_r[2*OUT_W-1:OUT_W] <= s2_r.err ? (s2_r.neg_y ? O_MIN : O_MAX) : sat_q8(my_r);
      data_r[3*OUT_W-1:2*OUT_W] <= s2_r.depth;
    end
  end

  assign out_valid = v_r[2];
  assign out_data  = data_r;
  assign out_err   = err_r;

endmodule

// ----- sv/vertex_transform_perspective_top.sv -----
// ----------------------------------------------------------------------------
// vertex_transform_perspective_top
// Vertex transform with perspective divide, fully pipelined.
// ----------------------------------------------------------------------------
// Each request on the in_ stream carries one map point; each request on the
// out_ stream carries the projected screen x, screen y and depth in Q28.4,
// plus a divide error flag in out_tuser.
// A request passes five operand stages, a 58-stage restoring divider with
// one quotient bit per stage, and three stages for translation, zoom and
// saturation, the last being the output register. Throughput is one request
// per cycle unless the receiver stalls. When it stalls, the whole pipeline
// holds and in_tready drops only while a result waits in the output register;
// nothing is lost or repeated. Synchronous reset clears all valid bits and
// the configuration registers; zoom resets to 1. Registers lie at byte
// address 8*i on the 64-bit configuration port; the user must write them
// only while no request is in flight, and the block does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_transform_perspective_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // point_x, point_y, point_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // screen_x, screen_y, depth
  output logic        out_tuser,  // divide_error
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import vtp_pkg::*;

  cfg_t             cfg;
  logic             ce;
  logic             f_valid, d_valid;
  side_t            f_side, d_side;
  logic [NUM_W-1:0] f_num_x, f_num_y, d_quo_x, d_quo_y;
  logic [MD_W-1:0]  f_md;

  assign cfg_pready = 1'b1;
  assign ce         = !out_tvalid || out_tready;
  assign in_tready  = ce;

  vtp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  vtp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .point_x   (in_tdata[15:0]),
    .point_y   (in_tdata[31:16]),
    .point_z   (in_tdata[47:32]),
    .out_valid (f_valid),
    .out_side  (f_side),
    .num_x     (f_num_x),
    .num_y     (f_num_y),
    .md        (f_md)
  );

  vtp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .num_x     (f_num_x),
    .num_y     (f_num_y),
    .md        (f_md),
    .out_valid (d_valid),
    .out_side  (d_side),
    .quo_x     (d_quo_x),
    .quo_y     (d_quo_y)
  );

  vtp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .cfg       (cfg),
    .in_valid  (d_valid),
    .in_side   (d_side),
    .quo_x     (d_quo_x),
    .quo_y     (d_quo_y),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_err   (out_tuser)
  );

  `VTP_ASSERT_IMP(a_err_sat_x, out_tvalid && out_tuser,
    out_tdata[31:0] == 32'h7fffffff || out_tdata[31:0] == 32'h80000000)
  `VTP_ASSERT_IMP(a_zero_zoom, out_tvalid && !out_tuser && cfg.zoom == 8'd0,
    out_tdata[63:0] == 64'd0)
  `VTP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule
